### hw/rtl/prd_pkg.sv
// Shared widths, register indexes and pipeline payload types for the pinhole ray block.
`timescale 1ns / 1ps

package prd_pkg;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_SCALE_X  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 2'd3;

  // Register formats.
  localparam int SCALE_W  = 25;
  localparam int OFFSET_W = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 25'h100_0000;

  // Normalization datapath.
  localparam int MAG_W  = 30;   // magnitudes after the common shift stay below 2^30
  localparam int MAGZ_W = 25;   // z magnitude is 2^24 shifted right
  localparam logic [MAGZ_W-1:0] Z_ONE = 25'h100_0000;
  localparam int SUM_W  = 62;   // sum of three squares
  localparam int ROOT_W = 31;   // floor of its square root
  localparam int FRAC_W = 15;   // fraction bits of the Q1.15 result
  localparam int NUM_W  = MAG_W + FRAC_W + 1;
  localparam int QUO_W  = FRAC_W + 1;

  // Result fields.
  localparam int DIR_W       = 16;
  localparam int DIRZ_W      = 15;
  localparam int OUT_TDATA_W = 48;

  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Shifted magnitudes and signs that travel with the sum through the root stages.
  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [MAGZ_W-1:0] mag_z;
  } ray_mag_t;

  // Signs that travel through the divider stages.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
  } ray_sign_t;

endpackage

### hw/rtl/pinhole_ray_direction.sv
// Top level of the pinhole camera ray generator: pixel in, unit ray direction out.
`timescale 1ns / 1ps

// Usage
//   The slave stream takes one pixel per beat: s_axis_tdata carries the column in the
//   lowest PIXEL_COORD_BITS bits and the row right above it. The master stream gives
//   one ray direction per beat: dir_x and dir_y as signed Q1.15 and dir_z as unsigned
//   Q0.15. The APB port holds scale_x, offset_x, scale_y and offset_y at byte
//   addresses 0, 4, 8 and 12; software writes them only while no beat is in flight.
//   Throughput is one pixel per cycle while the skid register is empty. The depth of
//   the pipeline comes from the square root, one result bit per stage over 31 stages,
//   and the three dividers, one quotient bit per stage over 16 stages.
//   Reset clears every valid bit and loads the identity intrinsics (both scales one,
//   both offsets zero). When the receiver stalls, the output register holds its beat
//   and one more beat lands in a skid register; s_axis_tready then drops and the
//   whole pipeline freezes in place until the skid register drains, so nothing is
//   lost or repeated.

module pinhole_ray_direction #(
  parameter int PIXEL_COORD_BITS = 12
) (
  input  logic                                        clk,
  input  logic                                        rst,
  // Configuration port.
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [prd_pkg::CFG_ADDR_W-1:0]              paddr,
  input  logic [prd_pkg::CFG_DATA_W-1:0]              pwdata,
  output logic [prd_pkg::CFG_DATA_W-1:0]              prdata,
  output logic                                        pready,
  // Pixel stream.
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // Fields from bit 0 up: pixel_column, pixel_row, zero padding.
  input  logic [((2*PIXEL_COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Ray stream.
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // Fields from bit 0 up: dir_x, dir_y, dir_z, zero padding.
  output logic [prd_pkg::OUT_TDATA_W-1:0]             m_axis_tdata
);

  import prd_pkg::*;

  localparam int PW       = PIXEL_COORD_BITS;
  localparam int PROD_W   = SCALE_W + PW;      // scale times coordinate
  localparam int SUMXY_W  = PROD_W + 2;        // product plus signed offset, two's complement
  localparam int ABS_W    = PROD_W + 1;        // magnitude of that sum
  localparam int SH_MAX   = ABS_W - MAG_W;     // largest common right shift
  localparam int SH_W     = $clog2(SH_MAX + 1);
  localparam int RES_W    = DIR_W + DIR_W + DIRZ_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only the word index of paddr is decoded.
  // ---------------------------------------------------------------------------
  logic [SCALE_W-1:0]  scale_x;
  logic [OFFSET_W-1:0] offset_x;
  logic [SCALE_W-1:0]  scale_y;
  logic [OFFSET_W-1:0] offset_y;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x  <= SCALE_RESET;
      offset_x <= '0;
      scale_y  <= SCALE_RESET;
      offset_y <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_SCALE_X:  scale_x  <= pwdata[SCALE_W-1:0];
        REG_OFFSET_X: offset_x <= pwdata[OFFSET_W-1:0];
        REG_SCALE_Y:  scale_y  <= pwdata[SCALE_W-1:0];
        REG_OFFSET_Y: offset_y <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCALE_X:  prdata = {{(CFG_DATA_W-SCALE_W){1'b0}}, scale_x};
      REG_OFFSET_X: prdata = offset_x;
      REG_SCALE_Y:  prdata = {{(CFG_DATA_W-SCALE_W){1'b0}}, scale_y};
      REG_OFFSET_Y: prdata = offset_y;
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage advances together; the only thing that stops
  // them is a full skid register at the output.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // Stage 1: capture the pixel.
  logic          v1;
  logic [PW-1:0] col1;
  logic [PW-1:0] row1;

  // Stage 2: scale the coordinates.
  logic              v2;
  logic [PROD_W-1:0] prod_x2;
  logic [PROD_W-1:0] prod_y2;

  // Stage 3: add the offsets and split into sign and magnitude.
  logic               v3;
  logic               neg_x3;
  logic               neg_y3;
  logic [ABS_W-1:0]   abs_x3;
  logic [ABS_W-1:0]   abs_y3;
  logic [SUMXY_W-1:0] sum_x;
  logic [SUMXY_W-1:0] sum_y;
  logic [SUMXY_W-1:0] mag_x_full;
  logic [SUMXY_W-1:0] mag_y_full;

  // Stage 4: find the common shift that brings the largest magnitude below 2^30.
  logic             v4;
  logic             neg_x4;
  logic             neg_y4;
  logic [ABS_W-1:0] abs_x4;
  logic [ABS_W-1:0] abs_y4;
  logic [SH_W-1:0]  shift4;
  logic [SH_W-1:0]  shift_next;
  logic [ABS_W-1:0] abs_or;

  // Stage 5: apply the shift.
  logic     v5;
  ray_mag_t mag5;

  // Stage 6: squares.
  logic                v6;
  ray_mag_t            mag6;
  logic [2*MAG_W-1:0]  sq_x6;
  logic [2*MAG_W-1:0]  sq_y6;
  logic [2*MAGZ_W-1:0] sq_z6;

  always_comb begin
    sum_x = {2'b00, prod_x2} + {{(SUMXY_W-OFFSET_W){offset_x[OFFSET_W-1]}}, offset_x};
    sum_y = {2'b00, prod_y2} + {{(SUMXY_W-OFFSET_W){offset_y[OFFSET_W-1]}}, offset_y};
    mag_x_full = sum_x[SUMXY_W-1] ? (~sum_x + 1'b1) : sum_x;
    mag_y_full = sum_y[SUMXY_W-1] ? (~sum_y + 1'b1) : sum_y;
  end

  // The z magnitude 2^24 never sets a bit at or above 2^30, so only x and y decide
  // the shift; the highest set bit of their OR is the highest bit of the larger one.
  always_comb begin
    abs_or     = abs_x3 | abs_y3;
    shift_next = '0;
    for (int b = MAG_W; b < ABS_W; b++) begin
      if (abs_or[b]) begin
        shift_next = SH_W'(b - (MAG_W - 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col1 <= s_axis_tdata[PW-1:0];
      row1 <= s_axis_tdata[2*PW-1:PW];

      prod_x2 <= PROD_W'(scale_x) * PROD_W'(col1);
      prod_y2 <= PROD_W'(scale_y) * PROD_W'(row1);

      neg_x3 <= sum_x[SUMXY_W-1];
      neg_y3 <= sum_y[SUMXY_W-1];
      abs_x3 <= mag_x_full[ABS_W-1:0];
      abs_y3 <= mag_y_full[ABS_W-1:0];

      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
      abs_x4 <= abs_x3;
      abs_y4 <= abs_y3;
      shift4 <= shift_next;

      mag5.neg_x <= neg_x4;
      mag5.neg_y <= neg_y4;
      mag5.mag_x <= MAG_W'(abs_x4 >> shift4);
      mag5.mag_y <= MAG_W'(abs_y4 >> shift4);
      mag5.mag_z <= MAGZ_W'(Z_ONE >> shift4);

      mag6  <= mag5;
      sq_x6 <= mag5.mag_x * mag5.mag_x;
      sq_y6 <= mag5.mag_y * mag5.mag_y;
      sq_z6 <= mag5.mag_z * mag5.mag_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: entry 0 holds the sum of squares, each following stage decides
  // one root bit from the top, keeping the remainder v - root^2.
  // ---------------------------------------------------------------------------
  logic              sq_v    [0:ROOT_W];
  logic [SUM_W-1:0]  sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  ray_mag_t          sq_mag  [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SUM_W'(sq_x6) + SUM_W'(sq_y6) + SUM_W'(sq_z6);
      sq_root[0] <= '0;
      sq_mag[0]  <= mag6;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int BIT = ROOT_W - 1 - k;
    localparam int TW  = SUM_W + 2;

    logic [TW-1:0] trial;
    logic          take;

    // Trial subtrahend (2*root + 2^BIT) * 2^BIT; the root only has bits above BIT.
    assign trial = (TW'(sq_root[k]) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign take  = {2'b00, sq_rem[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[k+1]  <= take ? (sq_rem[k] - trial[SUM_W-1:0]) : sq_rem[k];
        sq_root[k+1] <= take ? (sq_root[k] | (ROOT_W'(1) << BIT)) : sq_root[k];
        sq_mag[k+1]  <= sq_mag[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Three restoring dividers, one per component. The dividend is m * 2^15 plus
  // half the root, which rounds half up; the quotient never exceeds 2^15.
  // ---------------------------------------------------------------------------
  logic              dv_v    [0:QUO_W];
  ray_sign_t         dv_sign [0:QUO_W];
  logic [ROOT_W-1:0] dv_den  [0:QUO_W];
  logic [NUM_W-1:0]  dv_rem  [0:QUO_W][LANES];
  logic [QUO_W-1:0]  dv_quo  [0:QUO_W][LANES];
  logic [NUM_W-1:0]  half_root;

  assign half_root = NUM_W'(sq_root[ROOT_W] >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sign[0].neg_x <= sq_mag[ROOT_W].neg_x;
      dv_sign[0].neg_y <= sq_mag[ROOT_W].neg_y;
      dv_den[0]        <= sq_root[ROOT_W];
      dv_rem[0][LANE_X] <= (NUM_W'(sq_mag[ROOT_W].mag_x) << FRAC_W) + half_root;
      dv_rem[0][LANE_Y] <= (NUM_W'(sq_mag[ROOT_W].mag_y) << FRAC_W) + half_root;
      dv_rem[0][LANE_Z] <= (NUM_W'(sq_mag[ROOT_W].mag_z) << FRAC_W) + half_root;
      dv_quo[0][LANE_X] <= '0;
      dv_quo[0][LANE_Y] <= '0;
      dv_quo[0][LANE_Z] <= '0;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int BIT = QUO_W - 1 - k;

    logic [NUM_W:0] den_shifted;

    assign den_shifted = (NUM_W + 1)'(dv_den[k]) << BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_sign[k+1] <= dv_sign[k];
        dv_den[k+1]  <= dv_den[k];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic take;

      assign take = {1'b0, dv_rem[k][l]} >= den_shifted;

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[k+1][l] <= take ? (dv_rem[k][l] - den_shifted[NUM_W-1:0]) : dv_rem[k][l];
          dv_quo[k+1][l] <= take ? (dv_quo[k][l] | (QUO_W'(1) << BIT)) : dv_quo[k][l];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate to 32767, apply the signs and pack the beat.
  // ---------------------------------------------------------------------------
  logic [DIRZ_W-1:0] sat [LANES];
  logic [DIR_W-1:0]  dir_x;
  logic [DIR_W-1:0]  dir_y;
  logic [RES_W-1:0]  fin_data;
  logic              fin_valid;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sat[l] = dv_quo[QUO_W][l][QUO_W-1] ? {DIRZ_W{1'b1}} : dv_quo[QUO_W][l][DIRZ_W-1:0];
    end
    dir_x = dv_sign[QUO_W].neg_x ? (DIR_W'(0) - {1'b0, sat[LANE_X]}) : {1'b0, sat[LANE_X]};
    dir_y = dv_sign[QUO_W].neg_y ? (DIR_W'(0) - {1'b0, sat[LANE_Y]}) : {1'b0, sat[LANE_Y]};
    fin_data  = {sat[LANE_Z], dir_y, dir_x};
    fin_valid = dv_v[QUO_W];
  end

  // ---------------------------------------------------------------------------
  // Output register and skid register. While the skid register is empty the
  // pipeline runs, so a beat leaving the last stage either fills the output
  // register or, when the receiver holds off, parks in the skid register.
  // ---------------------------------------------------------------------------
  logic             out_valid;
  logic [RES_W-1:0] out_data;
  logic [RES_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
      end
    end else if (fin_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_data <= fin_data;
      end else begin
        skid_data <= fin_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_data};

endmodule

### bench/pinhole_ray_direction_tb.sv
// Self-checking testbench for the pinhole ray direction block: predicts each ray and compares.
`timescale 1ns / 1ps

module pinhole_ray_direction_tb;
  import prd_pkg::*;

  localparam int COORD_W = 12;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic [DIRZ_W-1:0]       dir_z;
  } ray_dir_t;

  // Every input starts at a known value; reset is held from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0 up: pixel_column, pixel_row.
  logic [2*COORD_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0 up: dir_x, dir_y, dir_z, zero padding.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Our own copy of the intrinsic registers, updated whenever the bench writes one.
  logic [SCALE_W-1:0]         cam_scale_x = SCALE_RESET;
  logic signed [OFFSET_W-1:0] cam_offset_x = '0;
  logic [SCALE_W-1:0]         cam_scale_y = SCALE_RESET;
  logic signed [OFFSET_W-1:0] cam_offset_y = '0;

  pixel_t   pixels_to_send[$];
  ray_dir_t rays_due[$];
  logic     pixel_taken = 1'b0;
  // While calm is set neither side idles, so the pipeline runs at full rate.
  bit       calm = 1'b0;
  int       errors = 0;
  int       rays_checked = 0;
  int       settings_used = 1;
  int       last_col = 0;

  pinhole_ray_direction #(
    .PIXEL_COORD_BITS(COORD_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact integer square root, digit by digit, floor of the true root.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe >>= 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // Component magnitude in Q1.15, rounded half up and clamped so it never reaches one.
  function automatic logic [DIR_W-1:0] unit_mag(longint unsigned m, longint unsigned r);
    longint unsigned q;
    q = ((m << FRAC_W) + (r >> 1)) / r;
    return (q > 32767) ? 16'd32767 : q[DIR_W-1:0];
  endfunction

  // Ray through one pixel under the current intrinsics.
  function automatic ray_dir_t predict_ray(pixel_t pix);
    longint          px;
    longint          py;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned az;
    longint unsigned peak;
    longint unsigned r;
    logic [DIR_W-1:0] qx;
    logic [DIR_W-1:0] qy;
    logic [DIR_W-1:0] qz;
    bit              neg_x;
    bit              neg_y;
    int              sh;
    ray_dir_t        ray;
    px = longint'(cam_scale_x) * longint'(pix.col) + longint'(cam_offset_x);
    py = longint'(cam_scale_y) * longint'(pix.row) + longint'(cam_offset_y);
    neg_x = px < 0;
    neg_y = py < 0;
    ax = neg_x ? -px : px;
    ay = neg_y ? -py : py;
    az = longint'(Z_ONE);
    peak = (ax > ay) ? ax : ay;
    if (az > peak) peak = az;
    // One common right shift keeps all three magnitudes below 2^30.
    sh = 0;
    while ((peak >> sh) >= (64'd1 << MAG_W)) sh++;
    ax >>= sh;
    ay >>= sh;
    az >>= sh;
    r = root_floor(ax * ax + ay * ay + az * az);
    qx = unit_mag(ax, r);
    qy = unit_mag(ay, r);
    qz = unit_mag(az, r);
    ray.dir_x = neg_x ? -qx : qx;
    ray.dir_y = neg_y ? -qy : qy;
    ray.dir_z = qz[DIRZ_W-1:0];
    return ray;
  endfunction

  // Pixel driver: a new beat goes out at the falling edge once the previous one was taken.
  always @(negedge clk) begin : pixel_driver
    pixel_t pix;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || pixel_taken) begin
      if (pixels_to_send.size() != 0 && (calm || $urandom_range(99) >= 23)) begin
        pix = pixels_to_send.pop_front();
        s_axis_tdata <= {pix.row, pix.col};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The ray receiver stalls at random unless the run is in its calm stretch.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 23);
    end
  end

  // Monitor: predicts on every accepted pixel and checks every accepted ray.
  always @(posedge clk) begin : ray_monitor
    pixel_t   pix;
    ray_dir_t want;
    ray_dir_t got;
    pixel_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      pix.col = s_axis_tdata[COORD_W-1:0];
      pix.row = s_axis_tdata[2*COORD_W-1:COORD_W];
      rays_due.push_back(predict_ray(pix));
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.dir_x = m_axis_tdata[DIR_W-1:0];
      got.dir_y = m_axis_tdata[2*DIR_W-1:DIR_W];
      got.dir_z = m_axis_tdata[2*DIR_W+DIRZ_W-1:2*DIR_W];
      if (rays_due.size() == 0) begin
        $error("ray beat with no pixel waiting for it: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = rays_due.pop_front();
        rays_checked++;
        if (got.dir_x !== want.dir_x) begin
          $error("dir_x: expected %0d, got %0d", want.dir_x, got.dir_x);
          errors++;
        end
        if (got.dir_y !== want.dir_y) begin
          $error("dir_y: expected %0d, got %0d", want.dir_y, got.dir_y);
          errors++;
        end
        if (got.dir_z !== want.dir_z) begin
          $error("dir_z: expected %0d, got %0d", want.dir_z, got.dir_z);
          errors++;
        end
      end
    end
  end

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Loads all four intrinsics and mirrors them into the predictor.
  task automatic load_intrinsics(logic [SCALE_W-1:0] sx, logic [OFFSET_W-1:0] ox,
                                 logic [SCALE_W-1:0] sy, logic [OFFSET_W-1:0] oy);
    write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
    write_reg(REG_OFFSET_Y, oy);
    cam_scale_x = sx;
    cam_offset_x = ox;
    cam_scale_y = sy;
    cam_offset_y = oy;
    settings_used++;
  endtask

  task automatic shoot(int col, int row);
    pixel_t pix;
    pix.col = col[COORD_W-1:0];
    pix.row = row[COORD_W-1:0];
    pixels_to_send.push_back(pix);
  endtask

  // Holds the sender back until every ray in flight has come out, so the block is idle.
  task automatic drain();
    while (pixels_to_send.size() != 0 || rays_due.size() != 0 || s_axis_tvalid)
      @(posedge clk);
  endtask

  // Random intrinsics: typical focal lengths, any scale up to the register limit,
  // offsets either centered on some principal point or anywhere in 32 bits.
  task automatic random_intrinsics();
    logic [SCALE_W-1:0]  sc[2];
    logic [OFFSET_W-1:0] of[2];
    longint              centered;
    for (int a = 0; a < 2; a++) begin
      case ($urandom_range(2))
        0: sc[a] = SCALE_W'($urandom_range(32'h100_0000));
        1: sc[a] = SCALE_W'($urandom);
        default: sc[a] = SCALE_W'(32'h100_0000 / $urandom_range(50, 5000));
      endcase
      centered = -(longint'(sc[a]) * $urandom_range(4095));
      of[a] = $urandom_range(1) ? $urandom : centered[OFFSET_W-1:0];
    end
    load_intrinsics(sc[0], of[0], sc[1], of[1]);
  endtask

  // Mostly uniform pixels, with raster runs and the image borders mixed in.
  task automatic random_scan(int count);
    int col;
    int row;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0, 1: begin
          col = (last_col + 1) % 4096;
        end
        2: begin
          col = $urandom_range(1) ? 4095 : 0;
        end
        default: begin
          col = $urandom_range(4095);
        end
      endcase
      row = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 4095 : 0) : $urandom_range(4095);
      shoot(col, row);
      last_col = col;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity intrinsics straight out of reset: corners and alternating bit patterns.
    shoot(0, 0);
    shoot(4095, 4095);
    shoot(4095, 0);
    shoot(0, 4095);
    shoot(12'hAAA, 12'h555);
    shoot(12'h555, 12'hAAA);
    drain();

    // Scales above one at their maximum, offsets at both ends of their range; this
    // forces the largest common shift before the square root.
    load_intrinsics(25'h1FF_FFFF, 32'h8000_0000, 25'h1FF_FFFF, 32'h7FFF_FFFF);
    shoot(0, 0);
    shoot(4095, 4095);
    shoot(2048, 1);
    drain();

    // Zero scales with extreme offsets: x and y dwarf z, so the ray lies almost in
    // the image plane and z shrinks toward zero.
    load_intrinsics('0, 32'h7FFF_FFFF, '0, 32'h8000_0000);
    shoot(0, 0);
    shoot(4095, 4095);
    drain();

    // Everything zero: the ray points straight ahead and z saturates.
    load_intrinsics('0, '0, '0, '0);
    shoot(123, 456);
    drain();

    // Unit scales with the most negative offsets: sign flips across the image.
    load_intrinsics(SCALE_RESET, 32'h8000_0000, SCALE_RESET, 32'h8000_0000);
    shoot(4095, 0);
    shoot(0, 4095);
    drain();

    // A realistic camera with a raster scan, run without any idling on either side.
    load_intrinsics(25'd16777, -32'sd34359296, 25'd16777, -32'sd25769472);
    calm = 1'b1;
    for (int i = 0; i < 300; i++) shoot(1900 + i, 1500 + i / 100);
    drain();
    calm = 1'b0;

    // Random intrinsics, each phase separated by a full drain.
    for (int p = 0; p < 7; p++) begin
      random_intrinsics();
      random_scan(200);
      drain();
    end

    // Let anything stray come out before the verdict.
    repeat (70) @(posedge clk);
    $display("Checked %0d rays over %0d intrinsic settings, including zero and maximum",
             rays_checked, settings_used);
    $display("scales, extreme offsets, saturation and random stalls on both streams.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Safety net: the whole run needs far less than this.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
